@@ rtl/core/abwot_pkg.sv @@
`default_nettype none

package abwot_pkg;

    localparam int CFG_W  = 6;
    localparam int ADDR_W = 32;
    localparam int DATA_W = 8;

    localparam logic [CFG_W-1:0]  CFG_RESET = 6'd26;
    localparam logic [DATA_W-1:0] PAT_A     = 8'haa;
    localparam logic [DATA_W-1:0] PAT_B     = 8'h55;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // access kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // fault kinds
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_HIGH = 2'd1;
    localparam logic [1:0] FAULT_LOW  = 2'd2;

    // read-data check to apply on a transfer
    localparam logic [1:0] CHK_NONE = 2'd0;
    localparam logic [1:0] CHK_HIGH = 2'd1;
    localparam logic [1:0] CHK_ZERO = 2'd2;
    localparam logic [1:0] CHK_SCAN = 2'd3;

    // address select
    localparam logic [1:0] ASEL_ZERO = 2'd0;
    localparam logic [1:0] ASEL_SCAN = 2'd1;
    localparam logic [1:0] ASEL_TEST = 2'd2;

    // write data select
    localparam logic [1:0] DSEL_ZERO = 2'd0;
    localparam logic [1:0] DSEL_A    = 2'd1;
    localparam logic [1:0] DSEL_B    = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] check;
        logic       scan_clr;
        logic       scan_inc;
        logic       test_clr;
        logic       test_inc;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] addr_sel;
        logic [1:0] data_sel;
        logic       last;
    } abwot_cmd_t;

    typedef struct packed {
        logic cfg_zero;
        logic nbits_zero;
        logic scan_end;
        logic test_end;
        logic out_free;
    } abwot_status_t;

endpackage

`default_nettype wire

@@ rtl/core/abwot_ctrl.sv @@
`default_nettype none

module abwot_ctrl
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_command,
    output logic                         in_ready,
    input  wire abwot_pkg::abwot_status_t status,
    output abwot_pkg::abwot_cmd_t        cmd
);

    localparam logic [3:0] S_WAIT    = 4'd0;
    localparam logic [3:0] S_FILL    = 4'd1;
    localparam logic [3:0] S_W55     = 4'd2;
    localparam logic [3:0] S_RD      = 4'd3;
    localparam logic [3:0] S_WAA0    = 4'd4;
    localparam logic [3:0] S_BEGW    = 4'd5;
    localparam logic [3:0] S_BEGR    = 4'd6;
    localparam logic [3:0] S_RESTORE = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_ZERO = 2'd2;
    localparam logic [1:0] PH_SCAN = 2'd3;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WAIT;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign in_ready = (state_reg == S_WAIT);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cmd          = '0;
        cmd.check    = abwot_pkg::CHK_NONE;
        cmd.kind     = abwot_pkg::KIND_WRITE;
        cmd.addr_sel = abwot_pkg::ASEL_ZERO;
        cmd.data_sel = abwot_pkg::DSEL_ZERO;
        case (state_reg)
            S_WAIT:
            begin
                if (in_valid)
                begin
                    if (in_command == abwot_pkg::CMD_START)
                    begin
                        cmd.start    = 1'b1;
                        cmd.scan_clr = 1'b1;
                        state_next   = status.cfg_zero ? S_W55 : S_FILL;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_HIGH:
                            begin
                                cmd.check    = abwot_pkg::CHK_HIGH;
                                cmd.scan_inc = 1'b1;
                                state_next   = status.scan_end ? S_WAA0 : S_RD;
                            end
                            PH_ZERO:
                            begin
                                cmd.check    = abwot_pkg::CHK_ZERO;
                                cmd.scan_clr = 1'b1;
                                phase_next   = PH_SCAN;
                                state_next   = S_RD;
                            end
                            PH_SCAN:
                            begin
                                cmd.check    = abwot_pkg::CHK_SCAN;
                                cmd.scan_inc = 1'b1;
                                state_next   = status.scan_end ? S_RESTORE : S_RD;
                            end
                            default:
                            begin
                                // read data with no test running is dropped
                                state_next = S_WAIT;
                            end
                        endcase
                    end
                end
            end
            S_FILL:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.addr_sel = abwot_pkg::ASEL_SCAN;
                    cmd.data_sel = abwot_pkg::DSEL_A;
                    cmd.scan_inc = 1'b1;
                    state_next   = status.scan_end ? S_W55 : S_FILL;
                end
            end
            S_W55:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.data_sel = abwot_pkg::DSEL_B;
                    if (status.nbits_zero)
                    begin
                        state_next = S_WAA0;
                    end
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        phase_next   = PH_HIGH;
                        state_next   = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = abwot_pkg::KIND_READ;
                    cmd.addr_sel = abwot_pkg::ASEL_SCAN;
                    cmd.last     = 1'b1;
                    state_next   = S_WAIT;
                end
            end
            S_WAA0:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.data_sel = abwot_pkg::DSEL_A;
                    if (status.nbits_zero)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.test_clr = 1'b1;
                        state_next   = S_BEGW;
                    end
                end
            end
            S_BEGW:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.addr_sel = abwot_pkg::ASEL_TEST;
                    cmd.data_sel = abwot_pkg::DSEL_B;
                    state_next   = S_BEGR;
                end
            end
            S_BEGR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = abwot_pkg::KIND_READ;
                    cmd.last   = 1'b1;
                    phase_next = PH_ZERO;
                    state_next = S_WAIT;
                end
            end
            S_RESTORE:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.addr_sel = abwot_pkg::ASEL_TEST;
                    cmd.data_sel = abwot_pkg::DSEL_A;
                    cmd.test_inc = 1'b1;
                    state_next   = status.test_end ? S_FIN : S_BEGW;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = abwot_pkg::KIND_FINISH;
                    cmd.last   = 1'b1;
                    phase_next = PH_IDLE;
                    state_next = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_WAIT;
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/abwot_datapath.sv @@
`default_nettype none

module abwot_datapath
#(
    parameter int MAX_ADDRESS_BITS = 32
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [abwot_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic [abwot_pkg::DATA_W-1:0]        in_read_data,
    input  wire abwot_pkg::abwot_cmd_t               cmd,
    output abwot_pkg::abwot_status_t                 status,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [1:0]                               out_access_kind,
    output logic [abwot_pkg::ADDR_W-1:0]             out_access_address,
    output logic [abwot_pkg::DATA_W-1:0]             out_write_data,
    output logic [1:0]                               out_fault_kind,
    output logic [abwot_pkg::ADDR_W-1:0]             out_fault_address,
    output logic                                     out_passed,
    output logic                                     out_last
);

    localparam int CW = $clog2(MAX_ADDRESS_BITS + 1);

    logic [abwot_pkg::CFG_W-1:0]  mem_size_log2_reg;
    logic [CW-1:0]                nbits_reg;
    logic [CW-1:0]                cfg_bits;
    logic [CW-1:0]                scan_reg;
    logic [CW-1:0]                test_reg;
    logic                         any_fault_reg;
    logic [1:0]                   pend_fk_reg;
    logic [abwot_pkg::ADDR_W-1:0] pend_fa_reg;
    logic [1:0]                   fk;
    logic [abwot_pkg::ADDR_W-1:0] fa;
    logic [abwot_pkg::ADDR_W-1:0] scan_addr;
    logic [abwot_pkg::ADDR_W-1:0] test_addr;
    logic [abwot_pkg::ADDR_W-1:0] sel_addr;
    logic [abwot_pkg::DATA_W-1:0] sel_data;
    logic                         data_bad;

    logic                         valid_reg;
    logic [1:0]                   kind_reg;
    logic [abwot_pkg::ADDR_W-1:0] addr_reg;
    logic [abwot_pkg::DATA_W-1:0] wdata_reg;
    logic [1:0]                   fkind_reg;
    logic [abwot_pkg::ADDR_W-1:0] faddr_reg;
    logic                         passed_reg;
    logic                         last_reg;

    // size saturates at the widest supported address
    assign cfg_bits = (mem_size_log2_reg > abwot_pkg::CFG_W'(MAX_ADDRESS_BITS))
                    ? CW'(MAX_ADDRESS_BITS) : CW'(mem_size_log2_reg);

    assign scan_addr = abwot_pkg::ADDR_W'(1) << scan_reg;
    assign test_addr = abwot_pkg::ADDR_W'(1) << test_reg;
    assign data_bad  = (in_read_data != abwot_pkg::PAT_A);

    assign status.cfg_zero   = (cfg_bits == '0);
    assign status.nbits_zero = (nbits_reg == '0);
    assign status.scan_end   = ({1'b0, scan_reg} + 1'b1) >= {1'b0, nbits_reg};
    assign status.test_end   = ({1'b0, test_reg} + 1'b1) >= {1'b0, nbits_reg};
    assign status.out_free   = !valid_reg || out_ready;

    always_comb
    begin
        fk = abwot_pkg::FAULT_NONE;
        fa = '0;
        case (cmd.check)
            abwot_pkg::CHK_HIGH:
            begin
                if (data_bad)
                begin
                    fk = abwot_pkg::FAULT_HIGH;
                    fa = scan_addr;
                end
            end
            abwot_pkg::CHK_ZERO:
            begin
                if (data_bad)
                begin
                    fk = abwot_pkg::FAULT_LOW;
                    fa = test_addr;
                end
            end
            abwot_pkg::CHK_SCAN:
            begin
                // the bit under test itself holds 0x55 and is not flagged
                if (data_bad && (scan_reg != test_reg))
                begin
                    fk = abwot_pkg::FAULT_LOW;
                    fa = scan_addr;
                end
            end
            default:
            begin
                fk = abwot_pkg::FAULT_NONE;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.addr_sel)
            abwot_pkg::ASEL_SCAN: sel_addr = scan_addr;
            abwot_pkg::ASEL_TEST: sel_addr = test_addr;
            default:              sel_addr = '0;
        endcase
        case (cmd.data_sel)
            abwot_pkg::DSEL_A: sel_data = abwot_pkg::PAT_A;
            abwot_pkg::DSEL_B: sel_data = abwot_pkg::PAT_B;
            default:           sel_data = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_log2_reg <= abwot_pkg::CFG_RESET;
            nbits_reg         <= '0;
            scan_reg          <= '0;
            test_reg          <= '0;
            any_fault_reg     <= 1'b0;
            pend_fk_reg       <= abwot_pkg::FAULT_NONE;
            pend_fa_reg       <= '0;
            valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mem_size_log2_reg <= cfg_wr_data;
            end

            if (cmd.start)
            begin
                nbits_reg     <= cfg_bits;
                any_fault_reg <= 1'b0;
                pend_fk_reg   <= abwot_pkg::FAULT_NONE;
                pend_fa_reg   <= '0;
            end
            else if (cmd.check != abwot_pkg::CHK_NONE)
            begin
                pend_fk_reg <= fk;
                pend_fa_reg <= fa;
                if (fk != abwot_pkg::FAULT_NONE)
                begin
                    any_fault_reg <= 1'b1;
                end
            end
            else if (cmd.emit)
            begin
                // fault report rides on the first result only
                pend_fk_reg <= abwot_pkg::FAULT_NONE;
                pend_fa_reg <= '0;
            end

            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + 1'b1;
            end

            if (cmd.test_clr)
            begin
                test_reg <= '0;
            end
            else if (cmd.test_inc)
            begin
                test_reg <= test_reg + 1'b1;
            end

            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg   <= cmd.kind;
            addr_reg   <= sel_addr;
            wdata_reg  <= sel_data;
            fkind_reg  <= pend_fk_reg;
            faddr_reg  <= pend_fa_reg;
            passed_reg <= (cmd.kind == abwot_pkg::KIND_FINISH) && !any_fault_reg;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid          = valid_reg;
    assign out_access_kind    = kind_reg;
    assign out_access_address = addr_reg;
    assign out_write_data     = wdata_reg;
    assign out_fault_kind     = fkind_reg;
    assign out_fault_address  = faddr_reg;
    assign out_passed         = passed_reg;
    assign out_last           = last_reg;

endmodule

`default_nettype wire

@@ rtl/core/address_bus_walking_ones_test_unit.sv @@
// Address-bus walking-ones test sequencer for a byte memory of 2^n bytes.
// Input stream (s_axis): tuser = command (0 start, 1 read data returned),
// tdata = the returned byte. Output stream (m_axis): one transfer per memory
// access or finish report; tuser = access kind (write, read, finished),
// tlast marks the final transfer caused by one input transfer.
// cfg_wr_en/cfg_wr_data set mem_size_log2, sampled when a test starts;
// write it only while the block is idle.
// A start produces n+2 transfers (three when n is zero) and every read-data
// transfer 1 to 3; each ends with a read (the caller answers with the byte)
// or the finish report.
// Timing: an input transfer is taken while waiting for input, then its output
// transfers leave through the single output register, one per cycle unless
// stalled; s_axis_tready is high only while waiting for input.
// A stalled m_axis_tready holds the output register and the sequencer waits.
// Reset clears the sequencer to idle, drops any pending output and loads
// mem_size_log2 = 26. Read data arriving with no test running is dropped;
// a start during a test abandons it and begins a new one.
`default_nettype none

module address_bus_walking_ones_test_unit
#(
    parameter int MAX_ADDRESS_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,     // mem_size_log2
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] read_data
    input  wire logic [0:0]  s_axis_tuser,    // [0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] access_address, [39:32] write_data, [41:40] fault_kind,
    // [73:42] fault_address, [74] passed, [79:75] zero
    output logic [79:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,    // [1:0] access_kind
    output logic             m_axis_tlast     // last
);

    abwot_pkg::abwot_cmd_t    cmd;
    abwot_pkg::abwot_status_t status;

    logic [1:0]  access_kind;
    logic [31:0] access_address;
    logic [7:0]  write_data;
    logic [1:0]  fault_kind;
    logic [31:0] fault_address;
    logic        passed;

    abwot_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser[0]),
        .in_ready   (s_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    abwot_datapath #(
        .MAX_ADDRESS_BITS (MAX_ADDRESS_BITS)
    ) u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_read_data       (s_axis_tdata),
        .cmd                (cmd),
        .status             (status),
        .out_ready          (m_axis_tready),
        .out_valid          (m_axis_tvalid),
        .out_access_kind    (access_kind),
        .out_access_address (access_address),
        .out_write_data     (write_data),
        .out_fault_kind     (fault_kind),
        .out_fault_address  (fault_address),
        .out_passed         (passed),
        .out_last           (m_axis_tlast)
    );

    assign m_axis_tuser = access_kind;
    assign m_axis_tdata = {5'd0, passed, fault_address, fault_kind, write_data,
                           access_address};

endmodule

`default_nettype wire
